[hw/rtl/tmru_pkg.sv]
// Shared types and constants for the tile mip reference-count updater.
// Depends on nothing; imported by the top level, the checker and the testbench.
package tmru_pkg;

    localparam int X_W    = 6;
    localparam int Y_W    = 6;
    localparam int DMIP_W = 8;
    localparam int TMIP_W = 3;
    localparam int CNT_W  = 16;
    localparam int RMIP_W = 4;
    localparam int MC_W   = 4;

    localparam logic [MC_W-1:0]  MIP_COUNT_RST = 4'd8;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_EVICT = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [X_W-1:0]    region_x;
        logic [Y_W-1:0]    region_y;
        logic [DMIP_W-1:0] desired_mip;
    } in_word_t;

    typedef struct packed {
        req_kind_t         request_kind;
        logic [X_W-1:0]    tile_x;
        logic [Y_W-1:0]    tile_y;
        logic [TMIP_W-1:0] tile_mip;
        logic              last;
    } out_word_t;

    // tiles per side of mip level s
    function automatic int unsigned level_side(int unsigned grid, int unsigned s);
        level_side = (grid + (32'd1 << s) - 32'd1) >> s;
    endfunction

    // first count entry of mip level s (levels packed back to back)
    function automatic int unsigned level_base(int unsigned grid, int unsigned s);
        int unsigned base;
        int unsigned side;
        base = 0;
        for (int unsigned k = 0; k < s; k++) begin
            side = level_side(grid, k);
            base = base + side * side;
        end
        level_base = base;
    endfunction

endpackage

[hw/rtl/tmru_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tmru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tile_mip_refcount_update_top.sv]
// Tile mip reference-count updater, top level.
// Depends on tmru_pkg and tmru_ram.
//
// - s_ channel: one feedback word per region (region_x, region_y, desired_mip);
//   desired_mip is clamped to mip_count limited to 1..MIP_LEVELS. Regions
//   outside the GRID_TILES grid are dropped.
// - m_ channel: zero to MIP_LEVELS load/evict request words per feedback word,
//   last set on the final one. cfg_wr_en/cfg_wr_data write mip_count; the user
//   must write it only while idle, which the block itself does not enforce.
// - Sequence: a word crossing L (at most MIP_LEVELS) mip levels goes through
//   accept, region-mip read, first count read, one count read-modify-write
//   per level and flush; with no mip change it ends after the region-mip
//   read, out of grid at accept. The single read and write port of the count
//   RAM sets the one-level-per-cycle loop, unless a stalled m_ channel holds it.
// - Reset: a clearing pass over all 2*GRID_TILES^2 + MIP_LEVELS count entries
//   zeroes every count and sets every region mip to min(8, MIP_LEVELS);
//   s_ready stays low until it ends. mip_count returns to 8.
// - Stall: one request is held back until the next one (or the end of the
//   word) is known, so last can be set; a stalled m_ channel stalls the loop.
module tile_mip_refcount_update_top #(
    parameter int GRID_TILES = 64,
    parameter int MIP_LEVELS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tmru_pkg::in_word_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tmru_pkg::out_word_t       m_data,
    input  logic                      cfg_wr_en,
    input  logic [tmru_pkg::MC_W-1:0] cfg_wr_data
);
    import tmru_pkg::*;

    localparam int REGION_DEPTH = GRID_TILES * GRID_TILES;
    localparam int COUNT_DEPTH  = 2 * REGION_DEPTH + MIP_LEVELS;
    localparam int RA_W   = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int CA_W   = $clog2(COUNT_DEPTH);
    localparam int SUM_W  = CA_W + 1;
    localparam int LVL_W  = $clog2(MIP_LEVELS + 1);
    localparam int SIDX_W = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
    localparam int SIDE_W = $clog2(GRID_TILES + 1);
    localparam int GRID_W = $clog2(GRID_TILES + 1) + 1;
    localparam int RST_MIP_I = (int'(MIP_COUNT_RST) > MIP_LEVELS) ? MIP_LEVELS
                                                                 : int'(MIP_COUNT_RST);
    localparam logic [RMIP_W-1:0] RST_MIP  = RMIP_W'(RST_MIP_I);
    localparam logic [MC_W-1:0]   ML_C     = MC_W'(MIP_LEVELS);
    localparam logic [RMIP_W-1:0] ML_R     = RMIP_W'(MIP_LEVELS);
    localparam logic [LVL_W-1:0]  ML_L     = LVL_W'(MIP_LEVELS);
    localparam logic [CA_W-1:0]   CLR_LAST = CA_W'(COUNT_DEPTH - 1);
    localparam logic [CA_W-1:0]   CLR_RGN  = CA_W'(REGION_DEPTH);
    localparam logic [SUM_W-1:0]  CNT_LIM  = SUM_W'(COUNT_DEPTH);
    localparam logic [GRID_W-1:0] GRID_C   = GRID_W'(GRID_TILES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REGION,
        ST_FIRST,
        ST_STEP,
        ST_FLUSH
    } state_t;

    // per-level layout of the count RAM
    logic [CA_W-1:0]   lvl_base [MIP_LEVELS];
    logic [SIDE_W-1:0] lvl_side [MIP_LEVELS];

    for (genvar gi = 0; gi < MIP_LEVELS; gi++) begin : g_layout
        assign lvl_base[gi] = CA_W'(level_base(GRID_TILES, gi));
        assign lvl_side[gi] = SIDE_W'(level_side(GRID_TILES, gi));
    end

    // registers
    state_t            state_reg,      state_next;
    logic [CA_W-1:0]   clr_reg,        clr_next;
    logic [MC_W-1:0]   mip_count_reg,  mip_count_next;
    logic [X_W-1:0]    x_reg,          x_next;
    logic [Y_W-1:0]    y_reg,          y_next;
    logic [LVL_W-1:0]  want_reg,       want_next;
    logic [RA_W-1:0]   ridx_reg,       ridx_next;
    logic [LVL_W-1:0]  s_reg,          s_next;
    logic              finer_reg,      finer_next;
    logic [CA_W-1:0]   caddr_reg,      caddr_next;
    logic              pend_valid_reg, pend_valid_next;
    out_word_t         pend_reg,       pend_next;
    logic              m_valid_reg,    m_valid_next;
    out_word_t         m_data_reg,     m_data_next;

    // RAM ports
    logic              r_wr_en, r_rd_en;
    logic [RA_W-1:0]   r_wr_addr, r_rd_addr;
    logic [RMIP_W-1:0] r_wr_data, r_rd_data;
    logic              c_wr_en, c_rd_en;
    logic [CA_W-1:0]   c_wr_addr;
    logic [CNT_W-1:0]  c_wr_data, c_rd_data;

    // datapath
    logic [MC_W-1:0]            eff_mip;
    logic [LVL_W-1:0]           want_in;
    logic                       in_grid;
    logic [RA_W-1:0]            ridx_in;
    logic [RMIP_W-1:0]          cur_r;
    logic [LVL_W-1:0]           cur;
    logic [LVL_W-1:0]           s_step;
    logic [LVL_W-1:0]           lvl_q;
    logic [SIDX_W-1:0]          sidx;
    logic [X_W-1:0]             tx_q;
    logic [Y_W-1:0]             ty_q;
    logic [Y_W+SIDE_W-1:0]      prod;
    logic [SUM_W-1:0]           sum;
    logic [CA_W-1:0]            caddr_calc;
    logic                       upd, emit, last_lvl, stall, out_free;
    logic [CNT_W-1:0]           new_cnt;
    out_word_t                  req_word;

    tmru_ram #(
        .WIDTH (RMIP_W),
        .DEPTH (REGION_DEPTH)
    ) u_region_ram (
        .aclk    (aclk),
        .wr_en   (r_wr_en),
        .wr_addr (r_wr_addr),
        .wr_data (r_wr_data),
        .rd_en   (r_rd_en),
        .rd_addr (r_rd_addr),
        .rd_data (r_rd_data)
    );

    tmru_ram #(
        .WIDTH (CNT_W),
        .DEPTH (COUNT_DEPTH)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (c_rd_en),
        .rd_addr (caddr_calc),
        .rd_data (c_rd_data)
    );

    // input qualification: clamp desired mip, grid check, region index
    always_comb begin
        if (mip_count_reg == '0) begin
            eff_mip = MC_W'(1);
        end else if (mip_count_reg > ML_C) begin
            eff_mip = ML_C;
        end else begin
            eff_mip = mip_count_reg;
        end
        if (s_data.desired_mip > DMIP_W'(eff_mip)) begin
            want_in = LVL_W'(eff_mip);
        end else begin
            want_in = LVL_W'(s_data.desired_mip);
        end
        in_grid = (GRID_W'(s_data.region_x) < GRID_C) && (GRID_W'(s_data.region_y) < GRID_C);
        ridx_in = RA_W'(int'(s_data.region_y) * GRID_TILES + int'(s_data.region_x));
    end

    // level walk and count address
    always_comb begin
        cur_r  = (r_rd_data > ML_R) ? ML_R : r_rd_data;
        cur    = LVL_W'(cur_r);
        s_step = finer_reg ? (s_reg - LVL_W'(1)) : (s_reg + LVL_W'(1));
        lvl_q  = (state_reg == ST_FIRST) ? s_reg : s_step;
        sidx   = (lvl_q < ML_L) ? lvl_q[SIDX_W-1:0] : '0;
        tx_q   = x_reg >> lvl_q;
        ty_q   = y_reg >> lvl_q;
        prod   = (Y_W+SIDE_W)'(ty_q) * (Y_W+SIDE_W)'(lvl_side[sidx]);
        sum    = SUM_W'(lvl_base[sidx]) + SUM_W'(prod) + SUM_W'(tx_q);
        caddr_calc = (sum < CNT_LIM) ? sum[CA_W-1:0] : '0;
    end

    // count update for the current level
    always_comb begin
        if (finer_reg) begin
            upd     = (c_rd_data != CNT_MAX);
            emit    = (c_rd_data == '0);
            new_cnt = c_rd_data + CNT_W'(1);
        end else begin
            upd     = (c_rd_data != '0);
            emit    = (c_rd_data == CNT_W'(1));
            new_cnt = c_rd_data - CNT_W'(1);
        end
        last_lvl = finer_reg ? (s_reg == want_reg) : ((s_reg + LVL_W'(1)) == want_reg);
        out_free = !m_valid_reg || m_ready;
        stall    = emit && pend_valid_reg && !out_free;

        req_word.request_kind = finer_reg ? REQ_LOAD : REQ_EVICT;
        req_word.tile_x       = X_W'(x_reg >> s_reg);
        req_word.tile_y       = Y_W'(y_reg >> s_reg);
        req_word.tile_mip     = TMIP_W'(s_reg);
        req_word.last         = 1'b0;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        mip_count_next  = cfg_wr_en ? cfg_wr_data : mip_count_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        want_next       = want_reg;
        ridx_next       = ridx_reg;
        s_next          = s_reg;
        finer_next      = finer_reg;
        caddr_next      = caddr_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        r_wr_en   = 1'b0;
        r_wr_addr = ridx_reg;
        r_wr_data = RMIP_W'(want_reg);
        r_rd_en   = 1'b0;
        r_rd_addr = ridx_in;
        c_wr_en   = 1'b0;
        c_wr_addr = caddr_reg;
        c_wr_data = new_cnt;
        c_rd_en   = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                c_wr_en   = 1'b1;
                c_wr_addr = clr_reg;
                c_wr_data = '0;
                r_wr_en   = (clr_reg < CLR_RGN);
                r_wr_addr = clr_reg[RA_W-1:0];
                r_wr_data = RST_MIP;
                clr_next  = clr_reg + CA_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    x_next    = s_data.region_x;
                    y_next    = s_data.region_y;
                    want_next = want_in;
                    ridx_next = ridx_in;
                    if (in_grid) begin
                        r_rd_en    = 1'b1;
                        state_next = ST_REGION;
                    end
                end
            end
            ST_REGION: begin
                // region entry becomes the wanted mip; walk starts next cycle
                r_wr_en    = 1'b1;
                finer_next = (cur > want_reg);
                s_next     = (cur > want_reg) ? (cur - LVL_W'(1)) : cur;
                state_next = (cur == want_reg) ? ST_IDLE : ST_FIRST;
            end
            ST_FIRST: begin
                c_rd_en    = 1'b1;
                caddr_next = caddr_calc;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (!stall) begin
                    c_wr_en = upd;
                    if (emit) begin
                        // previous request is known not to be last
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = req_word;
                    end
                    if (last_lvl) begin
                        state_next = ST_FLUSH;
                    end else begin
                        c_rd_en    = 1'b1;
                        caddr_next = caddr_calc;
                        s_next     = s_step;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = pend_reg;
                    m_data_next.last = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        want_reg   <= want_next;
        ridx_reg   <= ridx_next;
        s_reg      <= s_next;
        finer_reg  <= finer_next;
        caddr_reg  <= caddr_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            mip_count_reg  <= MIP_COUNT_RST;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            mip_count_reg  <= mip_count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/tmru_checker.sv]
// Port-level checks for the tile mip reference-count updater, and the bind
// that attaches them to the top level. Depends on tmru_pkg.
module tmru_checker #(
    parameter int GRID_TILES = 64,
    parameter int MIP_LEVELS = 8
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input tmru_pkg::in_word_t        s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input tmru_pkg::out_word_t       m_data
);
    import tmru_pkg::*;

    // held result word must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset empties the output and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block not quiet after reset");

    // s_ready drops right after an in-grid word is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (int'(s_data.region_x) < GRID_TILES)
            && (int'(s_data.region_y) < GRID_TILES) |=> !s_ready)
        else $error("input taken again right after an in-grid word");

    // requests only name streamed levels
    a_mip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (MIP_LEVELS > 8) || (int'(m_data.tile_mip) < MIP_LEVELS))
        else $error("request for a mip level out of range");

endmodule

bind tile_mip_refcount_update_top tmru_checker #(
    .GRID_TILES (GRID_TILES),
    .MIP_LEVELS (MIP_LEVELS)
) u_tmru_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

[dv/tile_mip_refcount_update_top_tb.sv]
// Testbench for tile_mip_refcount_update_top: feeds feedback words and predicts
// the load and evict requests from a behavioral copy of the per-tile counts.
// Depends on tmru_pkg and the RTL of the block; needs no files or arguments.
module tile_mip_refcount_update_top_tb;
    import tmru_pkg::*;

    localparam int GRID       = 64;
    localparam int MIPS       = 8;
    localparam int REGIONS    = GRID * GRID;
    localparam int SLOTS      = GRID * GRID * 2 + MIPS;
    // worst word is MIPS levels plus accept, reads and flush; keep some slack
    localparam int SETTLE     = 24;
    localparam int PHASE_LEN  = 35;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_word_t        m_data;
    logic             cfg_wr_en;
    logic [MC_W-1:0]  cfg_wr_data;

    // model state: current mip per region, reference count per tile per mip
    logic [RMIP_W-1:0] region_mip [REGIONS];
    logic [CNT_W-1:0]  tile_refs [SLOTS];
    int unsigned       lvl_base [MIPS];
    int unsigned       lvl_side [MIPS];
    logic [MC_W-1:0]   mip_count_q;

    out_word_t pending_requests [$];
    int        mismatch_count;
    // set during a stretch where neither side idles
    bit        calm;

    tile_mip_refcount_update_top #(
        .GRID_TILES (GRID),
        .MIP_LEVELS (MIPS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // result side stalls about 28% of cycles outside the calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 28);
    end

    // mip_count clamped to 1..MIPS
    function automatic int unsigned mip_limit();
        if (mip_count_q == 0)
            return 1;
        if (mip_count_q > MIPS)
            return MIPS;
        return mip_count_q;
    endfunction

    function automatic void clear_counts();
        int unsigned base_acc;
        base_acc = 0;
        for (int s = 0; s < MIPS; s++) begin
            lvl_side[s] = (GRID + (1 << s) - 1) >> s;
            lvl_base[s] = base_acc;
            base_acc    = base_acc + lvl_side[s] * lvl_side[s];
        end
        foreach (region_mip[i])
            region_mip[i] = RMIP_W'((MIPS < 8) ? MIPS : 8);
        foreach (tile_refs[i])
            tile_refs[i] = '0;
        mip_count_q = MIP_COUNT_RST;
    endfunction

    function automatic out_word_t make_request(req_kind_t kind, int unsigned tx,
                                               int unsigned ty, int unsigned s);
        out_word_t r;
        r.request_kind = kind;
        r.tile_x       = tx[X_W-1:0];
        r.tile_y       = ty[Y_W-1:0];
        r.tile_mip     = s[TMIP_W-1:0];
        r.last         = 1'b0;
        return r;
    endfunction

    // Walk the levels between the region's current mip and the clamped wanted
    // mip, update the counts and queue the resulting requests in visit order.
    function automatic void apply_feedback(in_word_t w);
        int unsigned want, cur, s, rix, slot, tx, ty;
        out_word_t   reqs [$];
        want = w.desired_mip;
        if (want > mip_limit())
            want = mip_limit();
        rix = w.region_y * GRID + w.region_x;
        cur = region_mip[rix];
        if (cur > MIPS)
            cur = MIPS;
        s = cur;
        // finer: count up, load on leaving zero, hold at saturation
        while (s > want) begin
            s--;
            tx   = w.region_x >> s;
            ty   = w.region_y >> s;
            slot = lvl_base[s] + ty * lvl_side[s] + tx;
            if (tile_refs[slot] != CNT_MAX) begin
                if (tile_refs[slot] == 0)
                    reqs = {reqs, make_request(REQ_LOAD, tx, ty, s)};
                tile_refs[slot] = tile_refs[slot] + 1'b1;
            end
        end
        // coarser: count down, evict on reaching zero, never below zero
        while (s < want) begin
            tx   = w.region_x >> s;
            ty   = w.region_y >> s;
            slot = lvl_base[s] + ty * lvl_side[s] + tx;
            if (tile_refs[slot] != 0) begin
                if (tile_refs[slot] == 1)
                    reqs = {reqs, make_request(REQ_EVICT, tx, ty, s)};
                tile_refs[slot] = tile_refs[slot] - 1'b1;
            end
            s++;
        end
        region_mip[rix] = want[RMIP_W-1:0];
        if (reqs.size() > 0)
            reqs[reqs.size() - 1].last = 1'b1;
        pending_requests = {pending_requests, reqs};
    endfunction

    function automatic int field_bad(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Every accepted request word is checked against the oldest prediction.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_requests.size() == 0) begin
                $display("%0t: unexpected request word, expected none, actual %p",
                         $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_requests.pop_front();
                mismatch_count += field_bad("request_kind", 8'(want.request_kind),
                                            8'(m_data.request_kind));
                mismatch_count += field_bad("tile_x", 8'(want.tile_x), 8'(m_data.tile_x));
                mismatch_count += field_bad("tile_y", 8'(want.tile_y), 8'(m_data.tile_y));
                mismatch_count += field_bad("tile_mip", 8'(want.tile_mip),
                                            8'(m_data.tile_mip));
                mismatch_count += field_bad("last", 8'(want.last), 8'(m_data.last));
            end
        end
    end

    // One feedback word. Valid is left high after acceptance so back-to-back
    // words never lower and raise it in the same step; an idle cycle lowers it.
    task automatic send_feedback(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                 input logic [DMIP_W-1:0] d);
        in_word_t w;
        w.region_x    = x;
        w.region_y    = y;
        w.desired_mip = d;
        if (!calm) begin
            while ($urandom_range(99) < 28) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        apply_feedback(w);
    endtask

    // Wait for every predicted request, then let a word with no requests finish.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_requests.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_mip_count(input logic [MC_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mip_count_q = v;
    endtask

    // Corners of the region grid, finest and raw-maximum mip requests, a
    // repeat that changes nothing, and shared coarse tiles that must not reload.
    task automatic test_field_extremes();
        send_feedback(6'd0, 6'd0, 8'd0);      // full load, mip 7 down to 0
        send_feedback(6'd63, 6'd63, 8'd0);    // coarse tiles already referenced
        send_feedback(6'd63, 6'd0, 8'd0);
        send_feedback(6'd0, 6'd63, 8'd0);
        send_feedback(6'd0, 6'd0, 8'd0);      // no change
        send_feedback(6'd63, 6'd63, 8'd255);  // clamps to 8, evicts its own tiles
        send_feedback(6'd0, 6'd0, 8'd255);
        send_feedback(6'd63, 6'd0, 8'd128);
        send_feedback(6'd0, 6'd63, 8'd127);   // last region out, everything evicted
        send_feedback(6'd42, 6'd21, 8'd3);
        send_feedback(6'd42, 6'd21, 8'd5);    // partial step coarser
        send_feedback(6'd42, 6'd21, 8'd1);    // partial step finer
    endtask

    // Out-of-range counts act as 1 and 8; a count change leaves region mips
    // alone, so later words cross levels above the new count.
    task automatic test_mip_count_clamp();
        set_mip_count(4'd0);
        send_feedback(6'd5, 6'd9, 8'd200);    // clamps to 1: loads 7..1
        send_feedback(6'd5, 6'd9, 8'd0);
        send_feedback(6'd5, 6'd9, 8'd9);      // back up to 1 only
        set_mip_count(4'd15);
        send_feedback(6'd5, 6'd9, 8'd255);    // clamps to 8: evicts 1..7
        set_mip_count(4'd2);
        send_feedback(6'd30, 6'd17, 8'd99);   // loads 7..2
        set_mip_count(4'd8);
        send_feedback(6'd30, 6'd17, 8'd8);    // evicts 2..7
        send_feedback(6'd42, 6'd21, 8'd8);
    endtask

    // Random words, mostly clustered in a small window so counts climb above
    // one and loads and evictions interleave; each phase uses another count.
    task automatic test_random_feedback();
        logic [MC_W-1:0] counts [] = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd6, 4'd9, 4'd8};
        int unsigned     pick, win_x, win_y;
        logic [X_W-1:0]  x;
        logic [Y_W-1:0]  y;
        logic [DMIP_W-1:0] d;
        foreach (counts[p]) begin
            set_mip_count(counts[p]);
            calm  = (p == 3);
            win_x = $urandom_range(GRID - 8);
            win_y = $urandom_range(GRID - 8);
            repeat (PHASE_LEN) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    x = X_W'(win_x + $urandom_range(7));
                    y = Y_W'(win_y + $urandom_range(7));
                    d = DMIP_W'($urandom_range(9));
                end else if (pick < 90) begin
                    x = X_W'($urandom);
                    y = Y_W'($urandom);
                    d = DMIP_W'($urandom_range(9));
                end else begin
                    x = X_W'($urandom);
                    y = Y_W'($urandom);
                    d = DMIP_W'($urandom_range(255));
                end
                send_feedback(x, y, d);
            end
        end
        calm = 0;
    endtask

    initial begin
        s_valid       <= 1'b0;
        s_data        <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        m_ready       <= 1'b0;
        aresetn       <= 1'b0;
        calm           = 0;
        mismatch_count = 0;
        clear_counts();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // the clearing pass after reset holds s_ready low; send waits on it
        test_field_extremes();
        test_mip_count_clamp();
        test_random_feedback();
        drain();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // timeout covering the clearing pass plus ~300 words
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
